FILE: sv/sed_pkg.sv
// Package for the 3x3 edge filter stream: kernel weights, tap layout,
// register indexes and the controller/datapath command and status words.
// Used by sed_ctrl, sed_datapath and sobel_edge_3x3_stream_unit.
package sed_pkg;

	typedef logic signed [2:0] weight_t;
	typedef weight_t kernel_t [4][3][3];

	// [kernel][horizontal offset][vertical offset]
	localparam kernel_t KERNELS = '{
		'{'{-3'sd1,  3'sd0,  3'sd1}, '{-3'sd2,  3'sd0,  3'sd2}, '{-3'sd1,  3'sd0,  3'sd1}},
		'{'{-3'sd1, -3'sd2, -3'sd1}, '{ 3'sd0,  3'sd0,  3'sd0}, '{ 3'sd1,  3'sd2,  3'sd1}},
		'{'{ 3'sd0,  3'sd1,  3'sd2}, '{-3'sd1,  3'sd0,  3'sd1}, '{-3'sd2, -3'sd1,  3'sd0}},
		'{'{ 3'sd2,  3'sd1,  3'sd0}, '{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd0, -3'sd1, -3'sd2}}
	};

	localparam logic [1:0] KERN_H    = 2'd0;
	localparam logic [1:0] KERN_V    = 2'd1;
	localparam logic [1:0] KERN_D45  = 2'd2;
	localparam logic [1:0] KERN_D135 = 2'd3;

	// tap t of the window: horizontal index (0 left) and vertical index (0 up)
	localparam logic [1:0] TAP_A [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] TAP_B [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam int unsigned NUM_TAPS = 9;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_MODE   = 2'd2;

	localparam logic [1:0] MODE_DIAG45  = 2'd1;
	localparam logic [1:0] MODE_DIAG135 = 2'd2;

	localparam int unsigned CFG_W   = 13;
	localparam int unsigned SUM_W   = 12; // signed weighted sum
	localparam int unsigned MAG_W   = 11; // its magnitude, dividend width
	localparam int unsigned WSUM_W  = 5;  // signed weight total
	localparam int unsigned DIV_W   = 4;  // divisor magnitude
	localparam int unsigned CNT_W   = 4;

	typedef struct packed {
		logic             accept;
		logic             rd_en;
		logic [CNT_W-1:0] rd_tap;
		logic             div_load;
		logic             div_step;
		logic             div_store;
		logic             div_sel;
		logic             put;
	} sed_cmd_t;

	typedef struct packed {
		logic emits;
		logic two_kernels;
		logic out_free;
	} sed_status_t;

endpackage

FILE: sv/sed_ctrl.sv
// Sequencer of the edge filter: accepts words, steps the window reads and
// the shared divider, and hands the result to the output register.
// Depends on sed_pkg.
module sed_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sed_pkg::sed_status_t status,
	output sed_pkg::sed_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_PUT
	} state_t;

	localparam logic [sed_pkg::CNT_W-1:0] LAST_TAP  = sed_pkg::CNT_W'(sed_pkg::NUM_TAPS - 1);
	localparam logic [sed_pkg::CNT_W-1:0] READ_END  = sed_pkg::CNT_W'(sed_pkg::NUM_TAPS);
	localparam logic [sed_pkg::CNT_W-1:0] DIV_STORE = sed_pkg::CNT_W'(sed_pkg::MAG_W + 1);

	state_t                    state_q;
	logic [sed_pkg::CNT_W-1:0] cnt_q;
	logic                      sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && status.emits) begin
						state_q <= ST_READ;
						cnt_q   <= '0;
					end
				end
				ST_READ: begin
					if (cnt_q == READ_END) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						sel_q   <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_STORE) begin
						cnt_q <= '0;
						if (!sel_q && status.two_kernels) begin
							sel_q <= 1'b1;
						end else begin
							state_q <= ST_PUT;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PUT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.rd_tap    = cnt_q;
		cmd.div_sel   = sel_q;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.rd_en     = (state_q == ST_READ) && (cnt_q <= LAST_TAP);
		cmd.div_load  = (state_q == ST_DIV) && (cnt_q == '0);
		cmd.div_step  = (state_q == ST_DIV) && (cnt_q != '0) && (cnt_q != DIV_STORE);
		cmd.div_store = (state_q == ST_DIV) && (cnt_q == DIV_STORE);
		cmd.put       = (state_q == ST_PUT) && status.out_free;
	end

endmodule

FILE: sv/sed_datapath.sv
// Datapath of the edge filter: registers, frame counters, pixel ring,
// window accumulators, restoring divider and output register.
// Depends on sed_pkg; driven by sed_ctrl.
module sed_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [sed_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        action,
	input  logic [7:0]                  pixel,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [7:0]                  edge_value,
	output logic                        frame_last,
	input  sed_pkg::sed_cmd_t           cmd,
	output sed_pkg::sed_status_t        status
);

	localparam int DEPTH = 2 * MAX_WIDTH + 3;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int LW    = $clog2(MAX_WIDTH + 3);
	localparam int HW    = 13;
	localparam int XW    = AW + 2;

	// configuration
	logic [10:0] width_q;
	logic [HW-1:0] height_q;
	logic [1:0]  mode_q;

	logic [13:0]   w_ext;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	assign w_ext = 14'(width_q);
	always_comb begin
		priority if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > 14'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
	end
	assign h_eff = (height_q == '0) ? HW'(1) : height_q;

	// frame position
	logic [WW-1:0] col_q, ox_q;
	logic [HW-1:0] row_q, oy_q;
	logic [LW-1:0] lag_q;
	logic [AW-1:0] wptr_q, cptr_q;

	logic recv_done, push, out_last, geo_write, clear;
	logic [LW-1:0] lag_inc, emit_lag;

	assign recv_done = (row_q == h_eff);
	assign push      = !action && !recv_done;
	assign lag_inc   = lag_q + 1'b1;
	assign emit_lag  = LW'(w_eff) + LW'(2);
	assign out_last  = (ox_q == w_eff - 1'b1) && (oy_q == h_eff - 1'b1);
	assign geo_write = cfg_we && (cfg_index == sed_pkg::CFG_WIDTH || cfg_index == sed_pkg::CFG_HEIGHT);
	assign clear     = geo_write || (cmd.put && out_last);

	assign status.emits       = push ? (lag_inc >= emit_lag) : (recv_done && lag_q != '0);
	assign status.two_kernels = !(mode_q == sed_pkg::MODE_DIAG45 || mode_q == sed_pkg::MODE_DIAG135);
	assign status.out_free    = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= HW'(480);
			mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sed_pkg::CFG_WIDTH:  width_q  <= cfg_data[10:0];
				sed_pkg::CFG_HEIGHT: height_q <= cfg_data[HW-1:0];
				sed_pkg::CFG_MODE:   mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			lag_q  <= '0;
			wptr_q <= '0;
			cptr_q <= '0;
		end else if (clear) begin
			col_q  <= '0;
			row_q  <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
			lag_q  <= '0;
			wptr_q <= '0;
			cptr_q <= '0;
		end else if (cmd.accept && push) begin
			wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			lag_q  <= lag_inc;
			if (col_q == w_eff - 1'b1) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (cmd.put) begin
			lag_q  <= lag_q - 1'b1;
			cptr_q <= (cptr_q == AW'(DEPTH - 1)) ? '0 : cptr_q + 1'b1;
			if (ox_q == w_eff - 1'b1) begin
				ox_q <= '0;
				oy_q <= oy_q + 1'b1;
			end else begin
				ox_q <= ox_q + 1'b1;
			end
		end
	end

	// pixel ring
	logic [7:0] ring_mem [DEPTH];
	logic [7:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept && push) begin
			ring_mem[wptr_q] <= pixel;
		end
	end

	// neighbour address and in-image test for the requested tap
	logic [1:0]          ta, tb;
	logic signed [XW-1:0] w_s, addr_x;
	logic [AW-1:0]       rd_addr;
	logic                in_win;

	assign ta  = sed_pkg::TAP_A[cmd.rd_tap];
	assign tb  = sed_pkg::TAP_B[cmd.rd_tap];
	assign w_s = $signed(XW'(w_eff));

	always_comb begin
		addr_x = $signed(XW'(cptr_q)) + $signed(XW'(ta)) - $signed(XW'(1));
		if (tb == 2'd0) begin
			addr_x = addr_x - w_s;
		end else if (tb == 2'd2) begin
			addr_x = addr_x + w_s;
		end
		if (addr_x < 0) begin
			addr_x = addr_x + $signed(XW'(DEPTH));
		end else if (addr_x >= $signed(XW'(DEPTH))) begin
			addr_x = addr_x - $signed(XW'(DEPTH));
		end
	end
	assign rd_addr = addr_x[AW-1:0];
	assign in_win  = !(ta == 2'd0 && ox_q == '0) && !(ta == 2'd2 && ox_q == w_eff - 1'b1)
		&& !(tb == 2'd0 && oy_q == '0) && !(tb == 2'd2 && oy_q == h_eff - 1'b1);

	logic       rd_v_s1, win_s1;
	logic [1:0] ta_s1, tb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= ring_mem[rd_addr];
			win_s1     <= in_win;
			ta_s1      <= ta;
			tb_s1      <= tb;
		end
	end

	// accumulators: kernel A is horizontal or a diagonal, kernel B vertical
	logic [1:0]                          kern_a;
	sed_pkg::weight_t                    wt_a, wt_b;
	logic signed [sed_pkg::SUM_W-1:0]    px_s, wa_s, wb_s;
	logic signed [sed_pkg::SUM_W-1:0]    sum_a_q, sum_b_q;
	logic signed [sed_pkg::WSUM_W-1:0]   wsum_a_q, wsum_b_q;

	always_comb begin
		unique case (mode_q)
			sed_pkg::MODE_DIAG45:  kern_a = sed_pkg::KERN_D45;
			sed_pkg::MODE_DIAG135: kern_a = sed_pkg::KERN_D135;
			default:               kern_a = sed_pkg::KERN_H;
		endcase
	end

	assign wt_a = sed_pkg::KERNELS[kern_a][ta_s1][tb_s1];
	assign wt_b = sed_pkg::KERNELS[sed_pkg::KERN_V][ta_s1][tb_s1];
	assign px_s = $signed({4'b0, rd_data_s1});
	assign wa_s = {{(sed_pkg::SUM_W-3){wt_a[2]}}, wt_a};
	assign wb_s = {{(sed_pkg::SUM_W-3){wt_b[2]}}, wt_b};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			wsum_a_q <= '0;
			wsum_b_q <= '0;
		end else if (rd_v_s1 && win_s1) begin
			sum_a_q  <= sum_a_q + px_s * wa_s;
			sum_b_q  <= sum_b_q + px_s * wb_s;
			wsum_a_q <= wsum_a_q + {{(sed_pkg::WSUM_W-3){wt_a[2]}}, wt_a};
			wsum_b_q <= wsum_b_q + {{(sed_pkg::WSUM_W-3){wt_b[2]}}, wt_b};
		end
	end

	// restoring divider on magnitudes: |s / w| == |s| / |w|
	logic signed [sed_pkg::SUM_W-1:0]  sel_sum;
	logic signed [sed_pkg::WSUM_W-1:0] sel_wsum;
	logic [sed_pkg::MAG_W-1:0]         mag;
	logic [sed_pkg::WSUM_W-1:0]        wmag;
	logic [sed_pkg::DIV_W-1:0]         dv_q, rem_q;
	logic [sed_pkg::MAG_W-1:0]         quo_q, qa_q, qb_q;
	logic [sed_pkg::DIV_W:0]           rem_sh;

	assign sel_sum  = cmd.div_sel ? sum_b_q : sum_a_q;
	assign sel_wsum = cmd.div_sel ? wsum_b_q : wsum_a_q;
	assign mag      = sel_sum[sed_pkg::SUM_W-1] ? sed_pkg::MAG_W'(-sel_sum)
		: sed_pkg::MAG_W'(sel_sum);
	assign wmag     = sel_wsum[sed_pkg::WSUM_W-1] ? -sel_wsum : sel_wsum;
	assign rem_sh   = {rem_q, quo_q[sed_pkg::MAG_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= mag;
			rem_q <= '0;
			dv_q  <= (wmag == '0) ? sed_pkg::DIV_W'(1) : wmag[sed_pkg::DIV_W-1:0];
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, dv_q}) begin
				rem_q <= sed_pkg::DIV_W'(rem_sh - {1'b0, dv_q});
				quo_q <= {quo_q[sed_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[sed_pkg::DIV_W-1:0];
				quo_q <= {quo_q[sed_pkg::MAG_W-2:0], 1'b0};
			end
		end else if (cmd.div_store) begin
			if (cmd.div_sel) begin
				qb_q <= quo_q;
			end else begin
				qa_q <= quo_q;
			end
		end
	end

	// result and output register
	logic [sed_pkg::MAG_W:0] pair_sum, res;

	assign pair_sum = {1'b0, qa_q} + {1'b0, qb_q};
	assign res      = status.two_kernels ? (pair_sum >> 1) : {1'b0, qa_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.put) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			edge_value <= (res > 12'd255) ? 8'd255 : res[7:0];
			frame_last <= out_last;
		end
	end

endmodule

FILE: sv/sobel_edge_3x3_stream_unit.sv
// Top level of the 3x3 Sobel / diagonal edge filter over a raster pixel stream.
// Instantiates sed_ctrl and sed_datapath; types and constants from sed_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | into      | in_valid / in_stall  | action, pixel
//  out     | out of    | out_valid / out_stall| edge_value, frame_last
//  cfg     | into      | cfg_we               | cfg_index, cfg_data
//
// A word that makes no result is taken without a stall. A word that makes a
// result goes through nine ring reads on the single memory port, one
// accumulate, then the shared one-bit-a-step divider for each kernel in use
// (one in modes 1 and 2, two in modes 0 and 3), and then the load of the
// output register.
// Reset clears the counters and restores the register defaults; the pixel ring
// needs no clearing. in_stall is high while a result is being worked out, and
// stays high while that result waits for the output register to free up; a
// finished word waits in the output register under out_stall and new input
// words are taken meanwhile.
module sobel_edge_3x3_stream_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [sed_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [7:0]                pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                edge_value,
	output logic                      frame_last
);

	sed_pkg::sed_cmd_t    cmd;
	sed_pkg::sed_status_t status;

	// sequencer: owns in_stall and steps the datapath
	sed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// ring, window sums, divider, output register
	sed_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (action),
		.pixel      (pixel),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.edge_value (edge_value),
		.frame_last (frame_last),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
